// File: hw/rtl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types and constants for the chunk integer sorter.
// ----------------------------------------------------------------------------
package cis_pkg;

	localparam int unsigned DATA_W = 32;

	// input request payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} req_t;

	// result payload
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflowed;
	} res_t;

	// value rippling from one cell to the next
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] data;
	} carry_t;

	// contents of one cell as seen by its left neighbor during drain
	typedef struct packed {
		logic                     full;
		logic signed [DATA_W-1:0] val;
	} slot_t;

endpackage

// File: hw/rtl/cis_cell.sv
// ----------------------------------------------------------------------------
// cis_cell
// One sorting cell: keeps the smaller of its value and the incoming one and
// passes the larger on, or shifts toward the output during drain.
// ----------------------------------------------------------------------------
module cis_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  cis_pkg::carry_t car_in,
	input  cis_pkg::slot_t  nxt_slot,
	output cis_pkg::carry_t car_out,
	output cis_pkg::slot_t  slot
);
	import cis_pkg::*;

	logic                     full_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     car_vld_q;
	logic signed [DATA_W-1:0] car_data_q;

	// occupancy and outgoing carry valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= 1'b0;
			car_vld_q <= 1'b0;
		end else begin
			car_vld_q <= 1'b0;
			if (shift_en) begin
				full_q <= nxt_slot.full;
			end else if (car_in.vld) begin
				full_q    <= 1'b1;
				car_vld_q <= full_q;
			end
		end
	end

	// stored value and carried value
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= nxt_slot.val;
		end else if (car_in.vld) begin
			if (!full_q) begin
				val_q <= car_in.data;
			end else if (car_in.data < val_q) begin
				val_q      <= car_in.data;
				car_data_q <= val_q;
			end else begin
				car_data_q <= car_in.data;
			end
		end
	end

	assign car_out.vld  = car_vld_q;
	assign car_out.data = car_data_q;
	assign slot.full    = full_q;
	assign slot.val     = val_q;

endmodule

// File: hw/rtl/chunk_integer_sorter.sv
// Load: takes one request per cycle; after the final request the cell row
// settles while the last values ripple into place. Drain: results then leave
// at one per cycle from the head cell, set by the shift of the cell row, while
// res_ready is high; no request is taken from the final request until the last
// result has moved into the output register. Reset (arst_n low) empties all cells.
// ----------------------------------------------------------------------------
// chunk_integer_sorter
// Systolic insertion sorter: a row of cells sorts a chunk of signed values
// as it loads and then drains it in ascending order.
// ----------------------------------------------------------------------------
module chunk_integer_sorter #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cis_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output cis_pkg::res_t res_data
);
	import cis_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             res_valid_q;
	res_t             res_q;

	carry_t                 car [MAX_ITEMS+1];
	slot_t                  slot [MAX_ITEMS];
	logic [MAX_ITEMS:0]     car_busy;
	logic                   req_acc;
	logic                   store_full;
	logic                   shift_en;
	logic                   busy;

	assign req_ready  = (state_q == ST_LOAD);
	assign req_acc    = req_valid && req_ready;
	assign store_full = (cnt_q == CNT_W'(MAX_ITEMS));
	assign shift_en   = (state_q == ST_DRAIN) && (cnt_q != '0) && (!res_valid_q || res_ready);

	// new value enters the head cell unless the store is full
	assign car[0].vld  = req_acc && !store_full;
	assign car[0].data = req_data.value;

	// cell row
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		slot_t nxt;
		if (i == MAX_ITEMS - 1) begin : g_tail
			assign nxt.full = 1'b0;
			assign nxt.val  = '0;
		end else begin : g_mid
			assign nxt = slot[i+1];
		end
		cis_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.car_in   (car[i]),
			.nxt_slot (nxt),
			.car_out  (car[i+1]),
			.slot     (slot[i])
		);
	end

	// any value still moving down the row
	always_comb begin
		for (int i = 0; i <= MAX_ITEMS; i++) begin
			car_busy[i] = car[i].vld;
		end
	end
	assign busy = |car_busy;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (req_acc) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (req_data.is_last) begin
							state_q <= ST_SETTLE;
						end
					end
				end
				ST_SETTLE: begin
					if (!busy) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (shift_en) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (shift_en) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			res_q.sorted_value <= slot[0].val;
			res_q.last_out     <= (cnt_q == CNT_W'(1));
			res_q.overflowed   <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: hw/rtl/cis_checker.sv
// ----------------------------------------------------------------------------
// cis_checker
// Port-level checks for the chunk integer sorter, bound to the top level.
// ----------------------------------------------------------------------------
module cis_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input cis_pkg::req_t req_data,
	input logic          res_valid,
	input logic          res_ready,
	input cis_pkg::res_t res_data
);
	import cis_pkg::*;

	// a result stays offered until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// the final request of a chunk closes the load
	a_load_closed: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.is_last |=> !req_ready)
		else $error("request taken right after the final request");

	// an offered result carries a known payload
	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !$isunknown(res_data))
		else $error("result offered with unknown payload");

endmodule

bind chunk_integer_sorter cis_checker u_cis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_data  (req_data),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
